// ===== src/cet_pkg.sv =====
// ----------------------------------------------------------------------------
// cet_pkg: shared types and constants for the confidence envelope tracker
// Widths, list depth, operation codes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package cet_pkg;
   localparam int ROWS         = 32;
   localparam int MAX_EXTREMES = 16;
   localparam int VALUE_BITS   = 32;
   localparam int SLOT_BITS    = $clog2(MAX_EXTREMES);
   localparam int MEM_DEPTH    = ROWS * MAX_EXTREMES;
   localparam int ADDR_BITS    = $clog2(MEM_DEPTH);
   localparam int ROWA_BITS    = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   localparam logic [1:0] OP_OBSERVED  = 2'd0;
   localparam logic [1:0] OP_SIMULATED = 2'd1;
   localparam logic [1:0] OP_REPORT    = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD,
      ST_SHIFT,
      ST_STORE,
      ST_READ,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ===== src/confidence_envelope_tracker.sv =====
// ----------------------------------------------------------------------------
// confidence_envelope_tracker: per-row extreme-value confidence envelope
// Serial divide, then a row of list cells loaded from RAM, updated, stored.
// A report passes ST_READ, then the rpt_ff register that drives its strobe.
// One item at a time: busy stays high until the FSM is idle again. A report
// goes through the read and report states; a row through the 48-step divide
// (skipped when q is one), the slot load (a clear when observed), one update
// and a 16-slot store. The receiver cannot stall. Reset: synchronous; clears
// a list-valid bit per row, count to 2.
// ----------------------------------------------------------------------------
`default_nettype none
module confidence_envelope_tracker (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [1:0]                               req_operation,
   input  wire logic [4:0]                               req_row_index,
   input  wire logic signed [31:0]                       req_q_value,
   input  wire logic signed [31:0]                       req_tau_value,
   input  wire logic signed [31:0]                       req_alpha_value,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [4:0]                               csr_data,
   output logic                                          rsp_strobe,
   output logic [4:0]                                    rsp_report_row,
   output logic signed [31:0]                            rsp_observed_dim,
   output logic signed [31:0]                            rsp_upper_bound,
   output logic signed [31:0]                            rsp_lower_bound,
   output logic signed [1:0]                             rsp_significance
);
   localparam int VB = cet_pkg::VALUE_BITS;
   localparam int ME = cet_pkg::MAX_EXTREMES;
   localparam int SB = cet_pkg::SLOT_BITS;
   localparam int AB = cet_pkg::ADDR_BITS;
   localparam int RB = cet_pkg::ROWA_BITS;

   cet_pkg::state_type state_ff, state_in;
   logic [4:0]     count_ff;
   logic [1:0]     op_ff;
   logic [RB-1:0]  row_ff;
   logic [cet_pkg::ROWS-1:0] row_valid_ff;
   logic [SB:0]    slot_ff, slot_in;
   logic signed [VB-1:0] value_ff, value_in;
   logic signed [VB-1:0] obs_ff [cet_pkg::ROWS];
   logic           row_live_ff, row_live_in;
   logic           q_one;
   logic           div_start, div_done;
   logic signed [VB-1:0] div_q;
   logic [SB-1:0]  neff;
   logic           accept;

   cet_pkg::cell_ctrl_type ctrl;
   logic signed [VB-1:0] low_q  [ME];
   logic signed [VB-1:0] high_q [ME];
   logic [ME-1:0] low_take, high_take;
   logic          low_gate, high_gate;
   logic signed [VB-1:0] load_low, load_high;
   logic [SB-1:0] load_slot;
   logic [ME-1:0] load_sel;

   logic           lo_we, hi_we;
   logic [AB-1:0]  mem_addr;
   logic [VB-1:0]  lo_rd, hi_rd, lo_wd, hi_wd;
   logic           rd_pending_ff, rd_pending_in;
   logic [SB-1:0]  rd_slot_ff, rd_slot_in;
   logic           rpt_ff;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign q_one     = (req_q_value == cet_pkg::Q_ONE);
   assign neff      = (count_ff < 5'd2) ? SB'(1) :
                      (32'(count_ff) > ME) ? SB'(ME - 1) : SB'(count_ff - 5'd1);

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 5'd2;
      else if (csr_valid && csr_ready) count_ff <= csr_data;
   end

   assign div_start = accept && req_operation != cet_pkg::OP_UNUSED
                      && 32'(req_row_index) < cet_pkg::ROWS && !q_one
                      && req_operation != cet_pkg::OP_REPORT;

   cet_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({req_tau_value, 16'd0}),
      .divisor  (33'(req_q_value) - 33'(cet_pkg::Q_ONE)),
      .done     (div_done),
      .quotient (div_q)
   );

   // an insert happens only when the value beats slot 0
   assign low_gate  = value_ff < low_q[0];
   assign high_gate = value_ff > high_q[0];

   // cell row: slot 0 is the bound slot, the top active slot is neff
   genvar g;
   generate
      for (g = 0; g < ME; g++) begin : g_cell
         cet_pkg::cell_ctrl_type c;
         always_comb begin
            c       = ctrl;
            c.load  = ctrl.load && load_sel[g];
         end
         cet_cell u_cell (
            .clock        (clock),
            .ctrl         (c),
            .active       (SB'(g) <= neff),
            .low_en       (low_gate),
            .high_en      (high_gate),
            .value        (value_ff),
            .load_low     (load_low),
            .load_high    (load_high),
            .up_low       ((g < ME-1) ? low_q[(g+1)%ME]  : low_q[g]),
            .up_high      ((g < ME-1) ? high_q[(g+1)%ME] : high_q[g]),
            .up_low_take  ((g < ME-1) ? low_take[(g+1)%ME]  : 1'b0),
            .up_high_take ((g < ME-1) ? high_take[(g+1)%ME] : 1'b0),
            .low_ff       (low_q[g]),
            .high_ff      (high_q[g]),
            .low_take     (low_take[g]),
            .high_take    (high_take[g])
         );
      end
   endgenerate

   always_comb begin
      load_sel = '0;
      load_sel[load_slot] = 1'b1;
   end

   assign load_slot = rd_slot_ff;
   assign load_low  = row_live_ff ? signed'(lo_rd) : cet_pkg::VMAX;
   assign load_high = row_live_ff ? signed'(hi_rd) : cet_pkg::VMIN;

   cet_ram #(.WIDTH(VB), .DEPTH(cet_pkg::MEM_DEPTH)) u_low_ram (
      .clock(clock), .write_en(lo_we), .addr(mem_addr),
      .write_data(lo_wd), .read_data(lo_rd));
   cet_ram #(.WIDTH(VB), .DEPTH(cet_pkg::MEM_DEPTH)) u_high_ram (
      .clock(clock), .write_en(hi_we), .addr(mem_addr),
      .write_data(hi_wd), .read_data(hi_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cet_pkg::ST_IDLE;
         rd_pending_ff <= 1'b0;
         rpt_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pending_ff <= rd_pending_in;
         rpt_ff        <= (state_ff == cet_pkg::ST_READ);
      end
      slot_ff     <= slot_in;
      value_ff    <= value_in;
      rd_slot_ff  <= rd_slot_in;
      row_live_ff <= row_live_in;
      if (accept) begin
         op_ff  <= req_operation;
         row_ff <= RB'(req_row_index);
      end
   end

   // per-row list-valid bit: a row is fresh until stored after a clear
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (state_ff == cet_pkg::ST_STORE && slot_ff == '0) begin
         row_valid_ff[row_ff] <= 1'b1;
      end else if (state_ff == cet_pkg::ST_SHIFT && op_ff == cet_pkg::OP_OBSERVED) begin
         row_valid_ff[row_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cet_pkg::ST_SHIFT && op_ff == cet_pkg::OP_OBSERVED)
         obs_ff[row_ff] <= value_ff;
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      rd_slot_in    = rd_slot_ff;
      rd_pending_in = 1'b0;
      row_live_in   = row_live_ff;
      ctrl          = '0;
      lo_we         = 1'b0;
      hi_we         = 1'b0;
      mem_addr      = {row_ff, slot_ff[SB-1:0]};
      lo_wd         = low_q[slot_ff[SB-1:0]];
      hi_wd         = high_q[slot_ff[SB-1:0]];
      busy          = (state_ff != cet_pkg::ST_IDLE);
      unique case (state_ff)
         cet_pkg::ST_IDLE: begin
            if (accept && 32'(req_row_index) < cet_pkg::ROWS
                && req_operation != cet_pkg::OP_UNUSED) begin
               value_in = q_one ? req_alpha_value : value_ff;
               slot_in  = '0;
               if (req_operation == cet_pkg::OP_REPORT) state_in = cet_pkg::ST_READ;
               else if (q_one)                         state_in = cet_pkg::ST_LOAD;
               else                                     state_in = cet_pkg::ST_DIVIDE;
            end
         end
         cet_pkg::ST_DIVIDE: begin
            if (div_done) begin
               value_in = div_q;
               state_in = cet_pkg::ST_LOAD;
            end
         end
         cet_pkg::ST_LOAD: begin
            // read slot_ff; the registered read data, with rd_pending_ff, loads the cell
            mem_addr      = {row_ff, slot_ff[SB-1:0]};
            rd_pending_in = (op_ff == cet_pkg::OP_SIMULATED) && (slot_ff < (SB+1)'(ME));
            rd_slot_in    = slot_ff[SB-1:0];
            row_live_in   = row_valid_ff[row_ff];
            ctrl.load     = rd_pending_ff;
            if (op_ff == cet_pkg::OP_OBSERVED) begin
               ctrl.clear = 1'b1;
               state_in   = cet_pkg::ST_SHIFT;
            end else if (slot_ff == (SB+1)'(ME)) begin
               state_in = cet_pkg::ST_SHIFT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         cet_pkg::ST_SHIFT: begin
            ctrl.shift = (op_ff == cet_pkg::OP_SIMULATED);
            slot_in    = '0;
            state_in   = cet_pkg::ST_STORE;
         end
         cet_pkg::ST_STORE: begin
            lo_we = 1'b1;
            hi_we = 1'b1;
            if (slot_ff == (SB+1)'(ME - 1)) state_in = cet_pkg::ST_IDLE;
            else slot_in = slot_ff + 1'b1;
         end
         cet_pkg::ST_READ: begin
            mem_addr    = {row_ff, {SB{1'b0}}};
            row_live_in = row_valid_ff[row_ff];
            state_in    = cet_pkg::ST_REPORT;
         end
         cet_pkg::ST_REPORT: begin
            state_in = cet_pkg::ST_IDLE;
         end
         default: state_in = cet_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_strobe       = rpt_ff;
      rsp_report_row   = 5'(row_ff);
      rsp_observed_dim = obs_ff[row_ff];
      rsp_lower_bound  = row_live_ff ? signed'(lo_rd) : cet_pkg::VMAX;
      rsp_upper_bound  = row_live_ff ? signed'(hi_rd) : cet_pkg::VMIN;
      rsp_significance = 2'sd0;
      if (rsp_observed_dim < rsp_lower_bound) rsp_significance = -2'sd1;
      if (rsp_observed_dim > rsp_upper_bound) rsp_significance = 2'sd1;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == cet_pkg::ST_READ)
      else $error("report strobe without read");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || $past(req_operation) == cet_pkg::OP_UNUSED)
      else $error("accepted item did not raise busy");
   assert property (@(posedge clock) disable iff (reset)
      (lo_we || hi_we) |-> state_ff == cet_pkg::ST_STORE)
      else $error("list write outside store");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("strobe while idle");
endmodule
`default_nettype wire

// ===== src/cet_divider.sv =====
// ----------------------------------------------------------------------------
// cet_divider: serial signed divider
// Restoring divide of a 48-bit dividend by a 33-bit divisor, one bit a cycle,
// quotient truncated toward zero and saturated to the value range.
// ----------------------------------------------------------------------------
`default_nettype none
module cet_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [47:0]                    dividend,
   input  wire logic signed [32:0]                    divisor,
   output logic                                       done,
   output logic signed [cet_pkg::VALUE_BITS-1:0]      quotient
);
   logic [47:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [32:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [48:0] trial;
   logic [48:0] signed_q;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial  = {rem_ff, quo_ff[47]} - {16'd0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[47] ? 48'(-dividend) : dividend;
         dvs_in = divisor[32] ? 33'(-divisor) : divisor;
         neg_in = dividend[47] ^ divisor[32];
         cnt_in = 6'd48;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = run_ff && (cnt_ff == 6'd0) ? 1'b0 : (!run_ff && cnt_ff == 6'd0);
   assign signed_q = neg_ff ? 49'(-{1'b0, quo_ff}) : {1'b0, quo_ff};

   always_comb begin
      if ($signed(signed_q) > $signed(49'(cet_pkg::VMAX)))
         quotient = cet_pkg::VMAX;
      else if ($signed(signed_q) < $signed({{(49-cet_pkg::VALUE_BITS){1'b1}}, cet_pkg::VMIN}))
         quotient = cet_pkg::VMIN;
      else
         quotient = signed_q[cet_pkg::VALUE_BITS-1:0];
   end

   assert property (@(posedge clock) disable iff (reset) start |=> run_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) run_ff |-> cnt_ff != 6'd0)
      else $error("divider count underflow");
   assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start && cnt_ff == 6'd1) |=> !run_ff)
      else $error("divider overran");
endmodule
`default_nettype wire

// ===== src/cet_ram.sv =====
// ----------------------------------------------------------------------------
// cet_ram: generic single-port RAM
// One address a cycle, written and read together; registered read data shows the old word.
// ----------------------------------------------------------------------------
`default_nettype none
module cet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) mem_ff[addr] <= write_data;
      read_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ===== src/cet_cell.sv =====
// ----------------------------------------------------------------------------
// cet_cell: one slot of the working list row
// Holds one low and one high slot; on shift it takes the value or its upper
// neighbor's entry, depending on where the insert lands in the row.
// ----------------------------------------------------------------------------
`default_nettype none
module cet_cell (
   input  wire logic                                   clock,
   input  wire cet_pkg::cell_ctrl_type                 ctrl,
   input  wire logic                                   active,
   input  wire logic                                   low_en,
   input  wire logic                                   high_en,
   input  wire logic signed [cet_pkg::VALUE_BITS-1:0]  value,
   input  wire logic signed [cet_pkg::VALUE_BITS-1:0]  load_low,
   input  wire logic signed [cet_pkg::VALUE_BITS-1:0]  load_high,
   input  wire logic signed [cet_pkg::VALUE_BITS-1:0]  up_low,
   input  wire logic signed [cet_pkg::VALUE_BITS-1:0]  up_high,
   input  wire logic                                   up_low_take,
   input  wire logic                                   up_high_take,
   output logic signed [cet_pkg::VALUE_BITS-1:0]       low_ff,
   output logic signed [cet_pkg::VALUE_BITS-1:0]       high_ff,
   output logic                                        low_take,
   output logic                                        high_take
);
   logic signed [cet_pkg::VALUE_BITS-1:0] low_in, high_in;
   logic low_hit, high_hit;

   assign low_hit   = active && (value < low_ff);
   assign high_hit  = active && (value > high_ff);
   // take: insert point is at this slot or above
   assign low_take  = low_hit || up_low_take;
   assign high_take = high_hit || up_high_take;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctrl.clear) begin
         low_in  = cet_pkg::VMAX;
         high_in = cet_pkg::VMIN;
      end else if (ctrl.load) begin
         low_in  = load_low;
         high_in = load_high;
      end else if (ctrl.shift) begin
         if (low_en && up_low_take)
            low_in = up_low;
         else if (low_en && low_hit)
            low_in = value;
         if (high_en && up_high_take)
            high_in = up_high;
         else if (high_en && high_hit)
            high_in = value;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
   end
endmodule
`default_nettype wire

// ===== verif/confidence_envelope_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// confidence_envelope_tracker_tb: self-checking regression
// Drives observed, simulated and report rows through the command port, keeps
// its own per-row envelope lists, and checks every report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module confidence_envelope_tracker_tb;

   typedef struct packed {
      logic [1:0]         operation;
      logic [4:0]         row_index;
      logic signed [31:0] q_value;
      logic signed [31:0] tau_value;
      logic signed [31:0] alpha_value;
   } row_cmd_type;

   typedef struct packed {
      logic [4:0]         report_row;
      logic signed [31:0] observed_dim;
      logic signed [31:0] upper_bound;
      logic signed [31:0] lower_bound;
      logic signed [1:0]  significance;
   } envelope_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic [4:0] req_row_index = '0;
   logic signed [31:0] req_q_value = '0, req_tau_value = '0, req_alpha_value = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;
   logic rsp_strobe;
   logic [4:0] rsp_report_row;
   logic signed [31:0] rsp_observed_dim, rsp_upper_bound, rsp_lower_bound;
   logic signed [1:0] rsp_significance;

   confidence_envelope_tracker u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_row_index(req_row_index),
      .req_q_value(req_q_value), .req_tau_value(req_tau_value),
      .req_alpha_value(req_alpha_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_report_row(rsp_report_row),
      .rsp_observed_dim(rsp_observed_dim), .rsp_upper_bound(rsp_upper_bound),
      .rsp_lower_bound(rsp_lower_bound), .rsp_significance(rsp_significance)
   );

   row_cmd_type  pending_cmds[$];
   envelope_type expected_reports[$];
   logic signed [31:0] obs_dim[cet_pkg::ROWS];
   logic signed [31:0] low_kept[cet_pkg::ROWS][cet_pkg::MAX_EXTREMES];
   logic signed [31:0] high_kept[cet_pkg::ROWS][cet_pkg::MAX_EXTREMES];
   bit obs_queued[cet_pkg::ROWS];
   logic [4:0] kept_count;
   int  idle_pct = 0;
   int  failures = 0;
   longint cycles = 0;
   bit  drain_hold = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] gen_dimension(row_cmd_type c);
      longint num, den, quo;
      if (c.q_value == cet_pkg::Q_ONE) return c.alpha_value;
      num = longint'(c.tau_value) * 65536;
      den = longint'(c.q_value) - 65536;
      quo = num / den;
      if (quo > 64'sd2147483647) quo = 64'sd2147483647;
      if (quo < -64'sd2147483648) quo = -64'sd2147483648;
      return quo[31:0];
   endfunction

   task automatic fold_row(row_cmd_type c);
      logic signed [31:0] v;
      int r, n;
      envelope_type e;
      r = c.row_index;
      if (r >= cet_pkg::ROWS) return;
      case (c.operation)
         cet_pkg::OP_OBSERVED: begin
            obs_dim[r] = gen_dimension(c);
            for (int k = 0; k < cet_pkg::MAX_EXTREMES; k++) begin
               low_kept[r][k] = cet_pkg::VMAX;
               high_kept[r][k] = cet_pkg::VMIN;
            end
         end
         cet_pkg::OP_SIMULATED: begin
            v = gen_dimension(c);
            n = (kept_count < 2) ? 2 : (kept_count > cet_pkg::MAX_EXTREMES ?
                                        cet_pkg::MAX_EXTREMES : kept_count);
            if (v < low_kept[r][0]) begin
               for (int k = n - 1; k >= 0; k--) begin
                  if (v < low_kept[r][k]) begin
                     for (int j = 1; j <= k; j++) low_kept[r][j-1] = low_kept[r][j];
                     low_kept[r][k] = v;
                     break;
                  end
               end
            end
            if (v > high_kept[r][0]) begin
               for (int k = n - 1; k >= 0; k--) begin
                  if (v > high_kept[r][k]) begin
                     for (int j = 1; j <= k; j++) high_kept[r][j-1] = high_kept[r][j];
                     high_kept[r][k] = v;
                     break;
                  end
               end
            end
         end
         cet_pkg::OP_REPORT: begin
            e.report_row = c.row_index;
            e.observed_dim = obs_dim[r];
            e.upper_bound = high_kept[r][0];
            e.lower_bound = low_kept[r][0];
            e.significance = 2'sd0;
            if (obs_dim[r] < low_kept[r][0]) e.significance = -2'sd1;
            if (obs_dim[r] > high_kept[r][0]) e.significance = 2'sd1;
            expected_reports.push_back(e);
         end
         default: ;
      endcase
   endtask

   // driver: prediction happens at the accepting edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            fold_row(pending_cmds.pop_front());
         end
         if (!(start && !busy) && start) begin
         end else if (pending_cmds.size() > 0 && !drain_hold &&
                      $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_operation <= pending_cmds[0].operation;
            req_row_index <= pending_cmds[0].row_index;
            req_q_value <= pending_cmds[0].q_value;
            req_tau_value <= pending_cmds[0].tau_value;
            req_alpha_value <= pending_cmds[0].alpha_value;
         end else begin
            start <= 1'b0;
            req_operation <= 2'($urandom);
            req_q_value <= $urandom;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      envelope_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report transfer row %0d", rsp_report_row);
            failures++;
         end else begin
            e = expected_reports.pop_front();
            if (rsp_report_row !== e.report_row) begin
               $error("report_row exp %0d got %0d", e.report_row, rsp_report_row); failures++;
            end
            if (rsp_observed_dim !== e.observed_dim) begin
               $error("observed_dim exp %0d got %0d", e.observed_dim, rsp_observed_dim);
               failures++;
            end
            if (rsp_upper_bound !== e.upper_bound) begin
               $error("upper_bound exp %0d got %0d", e.upper_bound, rsp_upper_bound);
               failures++;
            end
            if (rsp_lower_bound !== e.lower_bound) begin
               $error("lower_bound exp %0d got %0d", e.lower_bound, rsp_lower_bound);
               failures++;
            end
            if (rsp_significance !== e.significance) begin
               $error("significance exp %0d got %0d", e.significance, rsp_significance);
               failures++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("confidence_envelope_tracker regression: fail");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_q();
      case ($urandom_range(5))
         0: return cet_pkg::Q_ONE;
         1: return $urandom;
         2: return cet_pkg::Q_ONE + $signed($urandom_range(8)) - 4;
         default: return $signed($urandom_range(6 * 65536)) - 2 * 65536;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_val();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(1) ? cet_pkg::VMAX : cet_pkg::VMIN;
         default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
      endcase
   endfunction

   task automatic add_cmd(logic [1:0] op, logic [4:0] r, logic signed [31:0] q,
                          logic signed [31:0] t, logic signed [31:0] a);
      row_cmd_type c;
      c = '{op, r, q, t, a};
      pending_cmds.push_back(c);
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || start) @(posedge clock);
      while (expected_reports.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_count(logic [4:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      kept_count = val;
      csr_valid <= 1'b0;
   endtask

   function automatic bit obs_written_any(int r);
      return obs_queued[r];
   endfunction

   function automatic void mark_obs(int r);
      obs_queued[r] = 1'b1;
   endfunction

   task automatic queue_random(int count);
      int r, s, nsim;
      for (int i = 0; i < count; ) begin
         r = $urandom_range(cet_pkg::ROWS - 1);
         if ($urandom_range(9) == 0) begin
            s = $urandom_range(cet_pkg::OP_UNUSED);
            if (s == cet_pkg::OP_REPORT && !obs_written_any(r)) s = cet_pkg::OP_UNUSED;
            add_cmd(2'(s), 5'(r), rand_q(), rand_val(), rand_val());
            i++;
         end else begin
            nsim = $urandom_range(40);
            add_cmd(cet_pkg::OP_OBSERVED, 5'(r), rand_q(), rand_val(), rand_val());
            mark_obs(r);
            for (int k = 0; k < nsim; k++) begin
               add_cmd($urandom_range(7) == 0 ? cet_pkg::OP_REPORT : cet_pkg::OP_SIMULATED,
                       5'(r), rand_q(), rand_val(), rand_val());
            end
            add_cmd(cet_pkg::OP_REPORT, 5'(r), rand_q(), rand_val(), rand_val());
            i += nsim + 2;
         end
      end
   endtask

   initial begin
      int phase_idle[4] = '{0, 67, 0, 25};
      logic [4:0] counts[6] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd1};
      kept_count = 5'd2;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, q == 1, saturation, ignored ops, empty report
      add_cmd(cet_pkg::OP_OBSERVED, 5'd0, cet_pkg::Q_ONE, 32'sd0, 32'sd12345);
      add_cmd(cet_pkg::OP_REPORT, 5'd0, 0, 0, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::Q_ONE, 0, cet_pkg::VMAX);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::Q_ONE, 0, cet_pkg::VMIN);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::Q_ONE + 1, cet_pkg::VMAX, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::Q_ONE - 1, cet_pkg::VMAX, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::VMIN, cet_pkg::VMIN, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd0, cet_pkg::VMAX, cet_pkg::VMAX, 0);
      add_cmd(cet_pkg::OP_REPORT, 5'd0, 0, 0, 0);
      add_cmd(cet_pkg::OP_OBSERVED, 5'd31, 32'sd0, cet_pkg::VMIN, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd31, 32'sd3 * 65536, 32'sd65536, 0);
      add_cmd(cet_pkg::OP_SIMULATED, 5'd31, 32'sd3 * 65536, -32'sd65536, 0);
      add_cmd(cet_pkg::OP_REPORT, 5'd31, -1, -1, -1);
      add_cmd(cet_pkg::OP_UNUSED, 5'd31, 0, 0, 0);
      add_cmd(cet_pkg::OP_OBSERVED, 5'd31, cet_pkg::Q_ONE, 0, 32'sd7);
      add_cmd(cet_pkg::OP_REPORT, 5'd31, 0, 0, 0);
      mark_obs(0); mark_obs(31);
      wait_idle();
      for (int p = 0; p < 6; p++) begin
         write_count(counts[p]);
         idle_pct = phase_idle[p % 4];
         queue_random(320);
         if (p == 1) begin
            while (pending_cmds.size() > 160) @(posedge clock);
            drain_hold = 1'b1;
            while (start) @(posedge clock);
            while (expected_reports.size() > 0) @(posedge clock);
            drain_hold = 1'b0;
         end
         wait_idle();
      end
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("confidence_envelope_tracker regression: pass");
      end else begin
         $display("confidence_envelope_tracker regression: fail");
      end
      $finish;
   end
endmodule

// ===== confidence_envelope_tracker.f =====
src/cet_pkg.sv
src/cet_divider.sv
src/cet_ram.sv
src/cet_cell.sv
src/confidence_envelope_tracker.sv
verif/confidence_envelope_tracker_tb.sv
